// ===== rtl/sieve_flags_to_prime_values_defines.svh =====
// ----------------------------------------------------------------------------
// sieve_flags_to_prime_values_defines
// assertion macros used by the checker file of the prime enumeration block
// ----------------------------------------------------------------------------
`ifndef SIEVE_FLAGS_TO_PRIME_VALUES_DEFINES_SVH
`define SIEVE_FLAGS_TO_PRIME_VALUES_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define SFPV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define SFPV_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfpv_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpv_pkg
// item types, register indexes and sequencer states of the prime enumeration block
// ----------------------------------------------------------------------------
package sfpv_pkg;

    localparam int NUM_CLASSES_W = 7;
    localparam int MODULUS_W     = 20;
    localparam int RESIDUE_W     = 20;
    localparam int POSITION_W    = 40;
    localparam int HALF_POS_W    = 20;
    localparam int FLAGS_W       = 64;
    localparam int VALUE_W       = 64;
    localparam int COUNT_W       = 32;
    localparam int CLASS_IDX_W   = 6;
    localparam int PRODUCT_W     = 40;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    // item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CLASSES   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHEEL_MODULUS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_VALUE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LOW     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_HIGH    = 3'd4;

    localparam logic [NUM_CLASSES_W-1:0] NUM_CLASSES_RESET   = 7'd8;
    localparam logic [MODULUS_W-1:0]     WHEEL_MODULUS_RESET = 20'd30;

    typedef struct packed {
        logic                   mode;
        logic [CLASS_IDX_W-1:0] class_index;
        logic [RESIDUE_W-1:0]   residue;
        logic [POSITION_W-1:0]  position;
        logic [FLAGS_W-1:0]     class_flags;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] prime_value;
        logic [COUNT_W-1:0] running_count;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FIND,
        ST_ADD,
        ST_CHECK,
        ST_FLUSH
    } state_t;

endpackage

// ===== rtl/sieve_flags_to_prime_values.sv =====
// ----------------------------------------------------------------------------
// sieve_flags_to_prime_values
// turns wheel-sieve survivor flags into prime values with a running count
// ----------------------------------------------------------------------------
// A load item writes one residue table entry and leaves the input open. A scan
// item keeps the input closed from its acceptance until its run is closed: the
// shared 20x20 multiplier first runs over the two halves of the position, low
// half first, then every set flag below the class count takes a table read, a
// 64-bit add and a bound compare, and a last find and a flush close the run.
// Output stalls lengthen the run whenever a value has to move into the output
// register while it is still full: at a later in-range value of the item, or
// when the final value is handed over at the close of the run.
// One in-range value is held back so that the final one of the item can be
// marked last.
module sieve_flags_to_prime_values #(
    parameter int MAX_CLASSES = 64
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  sfpv_pkg::in_item_t                      s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output sfpv_pkg::out_item_t                     m_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [sfpv_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [sfpv_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import sfpv_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CLASSES);

    // configuration
    logic [NUM_CLASSES_W-1:0] num_classes_reg;
    logic [MODULUS_W-1:0]     wheel_modulus_reg;
    logic [VALUE_W-1:0]       base_value_reg;
    logic [VALUE_W-1:0]       range_low_reg;
    logic [VALUE_W-1:0]       range_high_reg;

    // sequencer and datapath
    state_t                   state_reg, state_next;
    logic [POSITION_W-1:0]    pos_reg, pos_next;
    logic [VALUE_W-1:0]       acc_reg, acc_next;
    logic [VALUE_W-1:0]       sum_reg, sum_next;
    logic [MAX_CLASSES-1:0]   mask_reg, mask_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic [VALUE_W-1:0]       hold_value_reg, hold_value_next;
    logic [COUNT_W-1:0]       hold_count_reg, hold_count_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg, out_data_next;

    // residue table
    logic [RESIDUE_W-1:0]     residue_mem [MAX_CLASSES];
    logic [RESIDUE_W-1:0]     rd_data_reg;
    logic                     tbl_we;
    logic                     tbl_re;
    logic [ADDR_W-1:0]        tbl_raddr;

    logic [HALF_POS_W-1:0]    mul_b;
    logic [PRODUCT_W-1:0]     mul_p;
    logic [MAX_CLASSES-1:0]   lim_mask;
    logic [ADDR_W-1:0]        find_idx;
    logic                     in_range;
    logic                     out_free;
    logic                     s_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign out_free  = !out_valid_reg || m_ready;

    // shared multiplier, low half of the position first
    assign mul_b = (state_reg == ST_MUL_LO) ? pos_reg[HALF_POS_W-1:0]
                                            : pos_reg[POSITION_W-1:HALF_POS_W];
    assign mul_p = {{(PRODUCT_W-MODULUS_W){1'b0}}, wheel_modulus_reg}
                 * {{(PRODUCT_W-HALF_POS_W){1'b0}}, mul_b};

    assign in_range = (sum_reg >= range_low_reg) && (sum_reg <= range_high_reg);

    always_comb begin
        for (int i = 0; i < MAX_CLASSES; i++) begin
            lim_mask[i] = (NUM_CLASSES_W'(i) < num_classes_reg);
        end
    end

    // lowest surviving class still to visit
    always_comb begin
        find_idx = '0;
        for (int i = MAX_CLASSES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                find_idx = ADDR_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_classes_reg   <= NUM_CLASSES_RESET;
            wheel_modulus_reg <= WHEEL_MODULUS_RESET;
            base_value_reg    <= '0;
            range_low_reg     <= '0;
            range_high_reg    <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NUM_CLASSES:   num_classes_reg   <= cfg_data[NUM_CLASSES_W-1:0];
                CFG_WHEEL_MODULUS: wheel_modulus_reg <= cfg_data[MODULUS_W-1:0];
                CFG_BASE_VALUE:    base_value_reg    <= cfg_data;
                CFG_RANGE_LOW:     range_low_reg     <= cfg_data;
                CFG_RANGE_HIGH:    range_high_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        mask_next       = mask_reg;
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        hold_count_next = hold_count_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;
        tbl_we          = 1'b0;
        tbl_re          = 1'b0;
        tbl_raddr       = find_idx;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.mode == MODE_SCAN) begin
                        pos_next   = s_data.position;
                        mask_next  = s_data.class_flags[MAX_CLASSES-1:0] & lim_mask;
                        state_next = ST_MUL_LO;
                    end else begin
                        tbl_we = ({1'b0, s_data.class_index} < (CLASS_IDX_W + 1)'(MAX_CLASSES));
                    end
                end
            end
            ST_MUL_LO: begin
                acc_next   = base_value_reg + {{(VALUE_W-PRODUCT_W){1'b0}}, mul_p};
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                acc_next   = acc_reg
                           + {{(VALUE_W-PRODUCT_W-HALF_POS_W){1'b0}}, mul_p,
                              {HALF_POS_W{1'b0}}};
                state_next = ST_FIND;
            end
            ST_FIND: begin
                if (mask_reg == '0) begin
                    state_next = ST_FLUSH;
                end else begin
                    tbl_re     = 1'b1;
                    mask_next  = mask_reg & (mask_reg - {{(MAX_CLASSES-1){1'b0}}, 1'b1});
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                sum_next   = acc_reg + {{(VALUE_W-RESIDUE_W){1'b0}}, rd_data_reg};
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!in_range) begin
                    state_next = ST_FIND;
                end else if (!hold_valid_reg || out_free) begin
                    // the held value is known not to be the last one
                    if (hold_valid_reg) begin
                        out_valid_next              = 1'b1;
                        out_data_next.prime_value   = hold_value_reg;
                        out_data_next.running_count = hold_count_reg;
                        out_data_next.last          = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_value_next = sum_reg;
                    hold_count_next = count_reg + COUNT_W'(1);
                    count_next      = count_reg + COUNT_W'(1);
                    state_next      = ST_FIND;
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.prime_value   = hold_value_reg;
                    out_data_next.running_count = hold_count_reg;
                    out_data_next.last          = 1'b1;
                    hold_valid_next             = 1'b0;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        acc_reg        <= acc_next;
        sum_reg        <= sum_next;
        mask_reg       <= mask_next;
        hold_value_reg <= hold_value_next;
        hold_count_reg <= hold_count_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            residue_mem[s_data.class_index[ADDR_W-1:0]] <= s_data.residue;
        end
        if (tbl_re) begin
            rd_data_reg <= residue_mem[tbl_raddr];
        end
    end

endmodule

// ===== rtl/sfpv_checker.sv =====
// ----------------------------------------------------------------------------
// sfpv_checker
// port-level checks of the prime enumeration block, bound to its top level
// ----------------------------------------------------------------------------
`include "sieve_flags_to_prime_values_defines.svh"

module sfpv_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input sfpv_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input sfpv_pkg::out_item_t m_data
);
    import sfpv_pkg::*;

    // a stalled result keeps its value
    `SFPV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result item changed while stalled")

    // a scan item keeps the input closed while the multiplier runs
    `SFPV_ASSERT_NEXT(a_scan_busy, aclk, aresetn, s_valid && s_ready && (s_data.mode == MODE_SCAN), !s_ready, "input open right after a scan item")

    // a load item leaves the input open
    `SFPV_ASSERT_NEXT(a_load_quick, aclk, aresetn, s_valid && s_ready && (s_data.mode == MODE_LOAD), s_ready, "input closed after a load item")

    // consecutive results count up by one
    `SFPV_ASSERT_NEXT(a_count_step, aclk, aresetn, m_valid && m_ready, !m_valid || (m_data.running_count == $past(m_data.running_count) + 32'd1), "running count skipped")

endmodule

bind sieve_flags_to_prime_values sfpv_checker u_sfpv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
